// ----- rtl/core/rlru_pkg.sv -----
// Shared types, codes and default sizes for the reference-counted LRU result cache.
`default_nettype none

package rlru_pkg;

  localparam int DEF_ENTRIES     = 8;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_HANDLE_BITS = 32;
  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_COUNT_BITS  = 8;

  // Port field widths
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 64;
  localparam int HANDLE_W  = 32;
  localparam int SLOT_W    = 3;
  localparam int NOW_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 3;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_EVICT   = 2'd2,
    CMD_PUT     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_BUSY = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture a new request, restart the scan
    logic scan;    // read the entry at the scan address and advance
    logic commit;  // write back the chosen entry and load the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan address sits on the last entry
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/refcounted_lru_result_cache.sv -----
// Reference-counted LRU result cache: a small fully associative key/handle store.
//
// Requests enter on the in_ stream: in_tuser carries the command (lookup,
// release, evict oldest, put), in_tdata the key, handle, slot and time stamp.
// Each request gives exactly one result on the out_ stream: out_tuser carries
// the status, out_tdata the entry index and the returned handle.
// A request is served by one read pass over the entry RAMs, one entry per
// cycle, followed by a single write-back of the chosen entry, which also loads
// the result. A new request is taken only after the previous one has been
// written back; the read pass through the single RAM read port sets that pace.
// The result sits in an output register, so the block goes on with the next
// request while a result waits; a stalled receiver holds the block only when
// a second result is ready before the first has been taken.
// Reset empties every entry at once (per-entry valid bits) and clears the
// control state; no clearing pass is needed.
`default_nettype none

module refcounted_lru_result_cache #(
  parameter int ENTRIES     = rlru_pkg::DEF_ENTRIES,
  parameter int KEY_BITS    = rlru_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = rlru_pkg::DEF_HANDLE_BITS,
  parameter int TIME_BITS   = rlru_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS  = rlru_pkg::DEF_COUNT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // key[63:0], handle[95:64], slot[98:96], now[130:99], zero fill above
  input  wire logic [rlru_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[1:0]
  input  wire logic [rlru_pkg::CMD_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // entry_index[2:0], handle_out[34:3], zero fill above
  output logic      [rlru_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic      [rlru_pkg::STATUS_W-1:0]     out_tuser
);
  import rlru_pkg::*;

  dp_cmd_t               dp_cmd;
  dp_stat_t              dp_stat;
  logic [INDEX_W-1:0]    res_index;
  logic [HANDLE_W-1:0]   res_handle;

  rlru_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  rlru_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .req_command (in_tuser),
    .req_key     (in_tdata[63:0]),
    .req_handle  (in_tdata[95:64]),
    .req_slot    (in_tdata[98:96]),
    .req_now     (in_tdata[130:99]),
    .res_status  (out_tuser),
    .res_index   (res_index),
    .res_handle  (res_handle)
  );

  assign out_tdata = {(OUT_DATA_W - INDEX_W - HANDLE_W)'(0), res_handle, res_index};

  // A new result may only be loaded when the previous one is gone or leaving.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while still pending");

  // One request at a time: no second accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in progress");

  // A busy evict carries neither index nor handle.
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_BUSY) |-> (res_index == '0 && res_handle == '0))
    else $error("busy result with nonzero payload");

  // A write-back never overlaps a request load or a scan step.
  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> !dp_cmd.load && !dp_cmd.scan)
    else $error("write-back overlaps request load or scan");

endmodule

`default_nettype wire

// ----- rtl/core/rlru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/rlru_dp.sv -----
// Datapath: entry stores, scan and selection logic, write-back and result registers.
`default_nettype none

module rlru_dp #(
  parameter int ENTRIES     = rlru_pkg::DEF_ENTRIES,
  parameter int KEY_BITS    = rlru_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = rlru_pkg::DEF_HANDLE_BITS,
  parameter int TIME_BITS   = rlru_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS  = rlru_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rlru_pkg::dp_cmd_t               cmd,
  output rlru_pkg::dp_stat_t                   stat,
  input  wire logic [rlru_pkg::CMD_W-1:0]      req_command,
  input  wire logic [rlru_pkg::KEY_W-1:0]      req_key,
  input  wire logic [rlru_pkg::HANDLE_W-1:0]   req_handle,
  input  wire logic [rlru_pkg::SLOT_W-1:0]     req_slot,
  input  wire logic [rlru_pkg::NOW_W-1:0]      req_now,
  output logic      [rlru_pkg::STATUS_W-1:0]   res_status,
  output logic      [rlru_pkg::INDEX_W-1:0]    res_index,
  output logic      [rlru_pkg::HANDLE_W-1:0]   res_handle
);
  import rlru_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int TU_W   = TIME_BITS + COUNT_BITS;
  localparam int SCMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Request registers
  cmd_t                   cmd_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [TIME_BITS-1:0]   now_r;

  // Scan and selection
  logic [IDX_W-1:0]       addr_r;
  logic                   eval_r;
  logic [IDX_W-1:0]       didx_r;
  logic [ENTRIES-1:0]     valid_r;
  logic                   found_r;
  logic [TIME_BITS-1:0]   best_r;
  logic [IDX_W-1:0]       sel_idx_r;
  logic [HANDLE_BITS-1:0] sel_hnd_r;
  logic [COUNT_BITS-1:0]  sel_users_r;

  // Result registers
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [INDEX_W-1:0]     index_r, index_nxt;
  logic [HANDLE_W-1:0]    hout_r, hout_nxt;

  logic [TIME_BITS-1:0]   now_tr, now_eff;
  logic [TU_W-1:0]        ts_rdata, ts_wdata;
  logic [KEY_BITS-1:0]    key_rdata;
  logic [HANDLE_BITS-1:0] hnd_rdata;
  logic [TIME_BITS-1:0]   rd_time;
  logic [COUNT_BITS-1:0]  rd_users;
  logic                   rd_live, take;
  logic                   we_ts, we_kh;
  logic [TIME_BITS-1:0]   wr_time;
  logic [COUNT_BITS-1:0]  wr_users;

  assign now_tr  = TIME_BITS'(req_now);
  assign now_eff = (now_tr == '0) ? TIME_BITS'(1) : now_tr;

  rlru_ram #(.WIDTH(TU_W), .DEPTH(ENTRIES)) u_ts_ram (
    .clk   (clk),
    .we    (we_ts),
    .waddr (sel_idx_r),
    .wdata (ts_wdata),
    .raddr (addr_r),
    .rdata (ts_rdata)
  );

  rlru_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (we_kh),
    .waddr (sel_idx_r),
    .wdata (key_r),
    .raddr (addr_r),
    .rdata (key_rdata)
  );

  rlru_ram #(.WIDTH(HANDLE_BITS), .DEPTH(ENTRIES)) u_hnd_ram (
    .clk   (clk),
    .we    (we_kh),
    .waddr (sel_idx_r),
    .wdata (hnd_r),
    .raddr (addr_r),
    .rdata (hnd_rdata)
  );

  assign stat.scan_last = (addr_r == IDX_W'(ENTRIES - 1));

  // An entry never written since reset reads as empty with no users.
  always_comb begin
    if (valid_r[didx_r]) begin
      rd_time  = ts_rdata[TU_W-1:COUNT_BITS];
      rd_users = ts_rdata[COUNT_BITS-1:0];
    end else begin
      rd_time  = '0;
      rd_users = '0;
    end
    rd_live = (rd_time != '0);
    case (cmd_r)
      CMD_LOOKUP:  take = !found_r && rd_live && (key_rdata == key_r);
      CMD_RELEASE: take = rd_live && (SCMP_W'(didx_r) == SCMP_W'(slot_r));
      CMD_EVICT:   take = rd_live && (rd_users == '0) && (rd_time < best_r);
      default:     take = !found_r && !rd_live;
    endcase
  end

  // Write-back and result
  always_comb begin
    we_ts      = 1'b0;
    we_kh      = 1'b0;
    wr_time    = now_r;
    wr_users   = sel_users_r;
    status_nxt = ST_MISS;
    index_nxt  = '0;
    hout_nxt   = '0;
    case (cmd_r)
      CMD_LOOKUP: begin
        if (found_r) begin
          we_ts     = cmd.commit;
          index_nxt = INDEX_W'(sel_idx_r);
          hout_nxt  = HANDLE_W'(sel_hnd_r);
          if (sel_users_r == '1) begin
            status_nxt = ST_SAT;
          end else begin
            status_nxt = ST_OK;
            wr_users   = sel_users_r + COUNT_BITS'(1);
          end
        end
      end
      CMD_RELEASE: begin
        index_nxt = slot_r;
        if (found_r) begin
          we_ts = cmd.commit;
          if (sel_users_r == '0) begin
            status_nxt = ST_SAT;
          end else begin
            status_nxt = ST_OK;
            wr_users   = sel_users_r - COUNT_BITS'(1);
          end
        end
      end
      CMD_EVICT: begin
        if (found_r) begin
          we_ts      = cmd.commit;
          wr_time    = '0;
          status_nxt = ST_OK;
          index_nxt  = INDEX_W'(sel_idx_r);
          hout_nxt   = HANDLE_W'(sel_hnd_r);
        end else begin
          status_nxt = ST_BUSY;
        end
      end
      default: begin
        if (found_r) begin
          we_ts      = cmd.commit;
          we_kh      = cmd.commit;
          wr_users   = COUNT_BITS'(1);
          status_nxt = ST_OK;
          index_nxt  = INDEX_W'(sel_idx_r);
        end
      end
    endcase
  end

  assign ts_wdata = {wr_time, wr_users};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      eval_r <= cmd.scan;
      if (we_kh) begin
        valid_r[sel_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= addr_r;
    if (cmd.load) begin
      cmd_r   <= cmd_t'(req_command);
      key_r   <= KEY_BITS'(req_key);
      hnd_r   <= HANDLE_BITS'(req_handle);
      slot_r  <= req_slot;
      now_r   <= now_eff;
      best_r  <= now_eff;
      found_r <= 1'b0;
      addr_r  <= '0;
    end else begin
      if (cmd.scan && !stat.scan_last) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (eval_r && take) begin
        found_r     <= 1'b1;
        best_r      <= rd_time;
        sel_idx_r   <= didx_r;
        sel_hnd_r   <= hnd_rdata;
        sel_users_r <= rd_users;
      end
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
      hout_r   <= hout_nxt;
    end
  end

  assign res_status = status_r;
  assign res_index  = index_r;
  assign res_handle = hout_r;

endmodule

`default_nettype wire

// ----- rtl/core/rlru_ctrl.sv -----
// Controller: request sequencing state machine and result handshake.
`default_nettype none

module rlru_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire rlru_pkg::dp_stat_t  stat,
  output rlru_pkg::dp_cmd_t        cmd
);
  import rlru_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register can take the new result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the reference-counted LRU result cache.
`default_nettype none

module testbench;
  import rlru_pkg::*;

  localparam int LINES   = DEF_ENTRIES;
  localparam int REF_MAX = (1 << DEF_COUNT_BITS) - 1;

  typedef struct {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [NOW_W-1:0]    now;
  } request_t;

  typedef struct {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [HANDLE_W-1:0] handle;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Shadow copy of the cache lines
  logic [KEY_W-1:0]    line_key    [LINES];
  logic [HANDLE_W-1:0] line_handle [LINES];
  logic [NOW_W-1:0]    line_stamp  [LINES];
  int unsigned         line_refs   [LINES];

  reply_t     cache_replies[$];
  reply_t     reply_head;
  int         errors;
  bit         bubbles_on;
  logic [KEY_W-1:0] key_pool [8];

  refcounted_lru_result_cache DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic request_t make_req(cmd_t cmd, logic [KEY_W-1:0] key,
                                        logic [HANDLE_W-1:0] handle,
                                        logic [SLOT_W-1:0] slot, logic [NOW_W-1:0] now);
    request_t r;
    r.cmd    = cmd;
    r.key    = key;
    r.handle = handle;
    r.slot   = slot;
    r.now    = now;
    return r;
  endfunction

  // Apply one request to the shadow lines and return the reply it should give.
  function automatic reply_t cache_apply(request_t r);
    reply_t           res;
    logic [NOW_W-1:0] stamp;
    logic [NOW_W-1:0] oldest;
    bit               found;
    int               pick;
    int               i;
    res.status = ST_MISS;
    res.index  = '0;
    res.handle = '0;
    found      = 0;
    pick       = 0;
    stamp      = (r.now == '0) ? NOW_W'(1) : r.now;
    case (r.cmd)
      CMD_LOOKUP: begin
        for (i = 0; i < LINES; i++) begin
          if (!found && line_stamp[i] != '0 && line_key[i] == r.key) begin
            found         = 1;
            line_stamp[i] = stamp;
            if (line_refs[i] >= REF_MAX) begin
              res.status = ST_SAT;
            end else begin
              line_refs[i]++;
              res.status = ST_OK;
            end
            res.index  = INDEX_W'(i);
            res.handle = line_handle[i];
          end
        end
      end
      CMD_RELEASE: begin
        res.index = r.slot;
        if (r.slot < LINES && line_stamp[r.slot] != '0) begin
          line_stamp[r.slot] = stamp;
          if (line_refs[r.slot] == 0) begin
            res.status = ST_SAT;
          end else begin
            line_refs[r.slot]--;
            res.status = ST_OK;
          end
        end
      end
      CMD_EVICT: begin
        oldest = stamp;
        for (i = 0; i < LINES; i++) begin
          if (line_stamp[i] != '0 && line_refs[i] == 0 && line_stamp[i] < oldest) begin
            oldest = line_stamp[i];
            pick   = i;
            found  = 1;
          end
        end
        if (found) begin
          line_stamp[pick] = '0;
          res.status       = ST_OK;
          res.index        = INDEX_W'(pick);
          res.handle       = line_handle[pick];
        end else begin
          res.status = ST_BUSY;
        end
      end
      default: begin
        for (i = 0; i < LINES; i++) begin
          if (!found && line_stamp[i] == '0) begin
            found          = 1;
            line_key[i]    = r.key;
            line_handle[i] = r.handle;
            line_stamp[i]  = stamp;
            line_refs[i]   = 1;
            res.status     = ST_OK;
            res.index      = INDEX_W'(i);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!bubbles_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Entered right after a rising edge; leaves in_tvalid high after acceptance.
  task automatic send_request(request_t r);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {5'b0, r.now, r.slot, r.handle, r.key};
    do @(posedge clk); while (!in_tready);
    cache_replies.push_back(cache_apply(r));
  endtask

  // Hold the input idle until every pending reply has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cache_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_cache();
    send_request(make_req(CMD_LOOKUP, '0, '0, 3'd0, 32'd5));
    send_request(make_req(CMD_RELEASE, '1, '1, 3'd7, 32'd5));
    send_request(make_req(CMD_EVICT, '0, '0, 3'd0, '1));
  endtask

  task automatic test_fill_and_overflow();
    int i;
    send_request(make_req(CMD_PUT, '0, '1, 3'd0, 32'd0));
    send_request(make_req(CMD_PUT, '1, '0, 3'd7, '1));
    send_request(make_req(CMD_PUT, key_pool[0], 32'h1111_2222, 3'd0, 32'd10));
    send_request(make_req(CMD_PUT, key_pool[0], 32'h3333_4444, 3'd0, 32'd11));
    for (i = 4; i < LINES; i++)
      send_request(make_req(CMD_PUT, key_pool[i - 3], $urandom, 3'd0, 32'(8 + i)));
    // no free line left
    send_request(make_req(CMD_PUT, key_pool[7], $urandom, 3'd0, 32'd16));
  endtask

  task automatic test_lookup_order();
    send_request(make_req(CMD_LOOKUP, '1, '0, 3'd0, 32'd20));
    // duplicate key: lowest live line wins
    send_request(make_req(CMD_LOOKUP, key_pool[0], '0, 3'd0, 32'd21));
  endtask

  task automatic test_release_and_evict();
    send_request(make_req(CMD_EVICT, '0, '0, 3'd0, 32'd100));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd0, 32'd0));
    // stamp of one against a time of zero: not strictly older
    send_request(make_req(CMD_EVICT, '0, '0, 3'd0, 32'd0));
    send_request(make_req(CMD_EVICT, '0, '0, 3'd0, 32'd2));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd0, 32'd3));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd6, 32'd40));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd6, 32'd50));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd4, 32'd50));
    send_request(make_req(CMD_RELEASE, '0, '0, 3'd5, 32'd50));
    send_request(make_req(CMD_EVICT, '0, '0, 3'd0, 32'd50));
    repeat (3) send_request(make_req(CMD_EVICT, '0, '0, 3'd0, 32'd51));
  endtask

  // Drive one line's count up past the top and back down past zero.
  task automatic test_reference_saturation();
    int i;
    for (i = 0; i < REF_MAX + 5; i++)
      send_request(make_req(CMD_LOOKUP, '1, $urandom, 3'($urandom), 32'(60 + i)));
    for (i = 0; i < REF_MAX + 5; i++)
      send_request(make_req(CMD_RELEASE, {$urandom, $urandom}, $urandom, 3'd1,
                            32'(400 + i)));
  endtask

  task automatic test_random_traffic(int count);
    request_t         r;
    logic [NOW_W-1:0] tick;
    int               held[$];
    int               n;
    int               i;
    int               sel;
    tick = 32'd1000;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      bubbles_on = !(n >= count / 2 + 20 && n < count / 2 + 70);
      tick += 32'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 2) tick = $urandom;
      r.key    = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)]
                                              : {$urandom, $urandom};
      r.handle = $urandom;
      r.slot   = 3'($urandom);
      sel      = $urandom_range(0, 99);
      r.now    = (sel < 4) ? '0 : (sel < 7) ? '1 : (sel < 10) ? NOW_W'($urandom) : tick;
      sel      = $urandom_range(0, 99);
      if (sel < 30) begin
        r.cmd = CMD_LOOKUP;
      end else if (sel < 58) begin
        r.cmd = CMD_RELEASE;
        held.delete();
        for (i = 0; i < LINES; i++)
          if (line_stamp[i] != '0 && line_refs[i] > 0) held.push_back(i);
        if (held.size() != 0 && $urandom_range(0, 3) != 0)
          r.slot = 3'(held[$urandom_range(0, held.size() - 1)]);
      end else if (sel < 80) begin
        r.cmd = CMD_PUT;
      end else begin
        r.cmd = CMD_EVICT;
      end
      send_request(r);
    end
  endtask

  // Random ready pattern on the reply side
  initial begin : reply_sink
    int run;
    run        = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else if (!bubbles_on || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        run = $urandom_range(0, 6);
      end else begin
        out_tready <= 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cache_replies.size() == 0) begin
        $display("%0t: unexpected reply: status %0d index %0d handle %h",
                 $time, out_tuser, out_tdata[2:0], out_tdata[34:3]);
        errors++;
      end else begin
        reply_head = cache_replies.pop_front();
        if (out_tuser !== reply_head.status || out_tdata[2:0] !== reply_head.index ||
            out_tdata[34:3] !== reply_head.handle) begin
          $display("%0t: reply mismatch: expected status %0d index %0d handle %h, got %0d %0d %h",
                   $time, reply_head.status, reply_head.index, reply_head.handle,
                   out_tuser, out_tdata[2:0], out_tdata[34:3]);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int i;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_LOOKUP;
    errors     = 0;
    bubbles_on = 1;
    for (i = 0; i < LINES; i++) begin
      line_key[i]    = '0;
      line_handle[i] = '0;
      line_stamp[i]  = '0;
      line_refs[i]   = 0;
    end
    for (i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_cache();
    test_fill_and_overflow();
    test_lookup_order();
    test_release_and_evict();
    wait_drained();
    test_reference_saturation();
    test_random_traffic(220);

    wait_drained();
    repeat (2 * LINES + 6) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/rlru_pkg.sv
rtl/core/rlru_ram.sv
rtl/core/rlru_dp.sv
rtl/core/rlru_ctrl.sv
rtl/core/refcounted_lru_result_cache.sv
bench/testbench.sv
